// ===== rtl/modem_result_code_classifier_top_assert.svh =====
// Assertion macros for the result code classifier
`ifndef MODEM_RESULT_CODE_CLASSIFIER_TOP_ASSERT_SVH
`define MODEM_RESULT_CODE_CLASSIFIER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define MRCC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MRCC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MRCC_ASSERT(label, clk, rst, prop, msg)
`define MRCC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/mrcc_pkg.sv =====
package mrcc_pkg;

  localparam int CHAR_W      = 8;
  localparam int CODE_W      = 4;
  localparam int LEN_W       = 8;
  localparam int OUT_W       = 16;
  localparam int WIN_DEPTH   = 11;
  localparam int KEY_SPAN    = WIN_DEPTH + 1;
  localparam int NUM_KEYS    = 12;
  localparam int MAX_LINE_DEF = 256;

  localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0A;

  localparam logic [CODE_W-1:0] CODE_NONE = 4'd10;

  // keyword text right-aligned: byte i is the char i places before the newest
  localparam logic [KEY_SPAN*CHAR_W-1:0] KEY_TEXT [NUM_KEYS] = '{
    "ok", "error", "connect", "no carrier", "no dialtone", "no dial tone",
    "busy", "delayed", "voice", "fclass", "fax", "no answer"
  };

  localparam logic [3:0] KEY_LEN [NUM_KEYS] = '{
    4'd2, 4'd5, 4'd7, 4'd10, 4'd11, 4'd12, 4'd4, 4'd7, 4'd5, 4'd6, 4'd3, 4'd9
  };

  localparam logic [CODE_W-1:0] KEY_CODE [NUM_KEYS] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd8, 4'd9
  };

  function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // first keyword in table order wins
  function automatic logic [CODE_W-1:0] first_code(input logic [NUM_KEYS-1:0] seen);
    logic [CODE_W-1:0] r;
    r = CODE_NONE;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (seen[k]) begin
        r = KEY_CODE[k];
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/mrcc_window.sv =====
module mrcc_window (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              take,
  input  logic                              start,
  input  logic [mrcc_pkg::CHAR_W-1:0]       char_in,
  output logic [mrcc_pkg::NUM_KEYS-1:0]     seen
);
  import mrcc_pkg::*;

  logic [CHAR_W-1:0]   window [WIN_DEPTH];
  logic [CHAR_W-1:0]   recent [KEY_SPAN];
  logic [NUM_KEYS-1:0] hits;
  logic [NUM_KEYS-1:0] seen_next;

  always_comb begin
    recent[0] = fold_lower(char_in);
    for (int i = 0; i < WIN_DEPTH; i++) begin
      recent[i+1] = start ? '0 : window[i];
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      hits[k] = 1'b1;
      for (int i = 0; i < KEY_SPAN; i++) begin
        if (i < int'(KEY_LEN[k]) && recent[i] != KEY_TEXT[k][i*CHAR_W +: CHAR_W]) begin
          hits[k] = 1'b0;
        end
      end
    end
    seen_next = start ? hits : (seen | hits);
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        window[i] <= recent[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (take) begin
      seen <= seen_next;
    end
  end

endmodule

// ===== rtl/mrcc_out_buf.sv =====
`include "modem_result_code_classifier_top_assert.svh"

module mrcc_out_buf (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [mrcc_pkg::OUT_W-1:0]     in_data,
  output logic                           in_ready,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mrcc_pkg::OUT_W-1:0]     m_tdata
);
  import mrcc_pkg::*;

  logic             skid_valid;
  logic [OUT_W-1:0] skid_data;
  logic             out_fire;
  logic             to_skid;

  assign in_ready = !skid_valid;
  assign out_fire = m_tvalid && m_tready;
  assign to_skid  = in_valid && m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (to_skid) begin
        skid_valid <= 1'b1;
      end else begin
        m_tvalid <= 1'b1;
      end
    end else if (out_fire) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        m_tdata <= skid_data;
      end
    end else if (in_valid) begin
      if (to_skid) begin
        skid_data <= in_data;
      end else begin
        m_tdata <= in_data;
      end
    end
  end

  `MRCC_ASSERT(a_skid_has_out, clk, rst, skid_valid |-> m_tvalid, "skid full with output empty")
  `MRCC_ASSERT(a_skid_drain, clk, rst, (skid_valid && out_fire) |=> (m_tvalid && !skid_valid), "skid not drained")
  `MRCC_ASSERT(a_no_load_when_full, clk, rst, skid_valid |-> !in_valid, "item taken while skid full")

endmodule

// ===== rtl/modem_result_code_classifier_top.sv =====
// Modem result code classifier.
// Slave channel (s_*): one received byte per item in s_tdata[7:0]. Master
// channel (m_*): one item per closed line, result_code in m_tdata[3:0] and
// line_length (low 8 bits of the kept count) in m_tdata[11:4].
// CR/LF ahead of a line are dropped. A CR/LF inside a line, or a byte that
// would be character MAX_LINE, closes the line and emits one result; that
// byte is not kept.
// Throughput: one byte per cycle while s_tready is high. Each kept byte updates
// the 11-char window and the keyword hit flags in the cycle it is taken. The result
// for a closed line is registered into the output register, or into the skid if held.
// A two-entry output stage (output register plus skid) keeps s_tready high
// while one result waits; s_tready drops only when both entries are full,
// and rises again once the master takes an item.
// Reset (rst, synchronous): no line open, output stage empty.
`include "modem_result_code_classifier_top_assert.svh"

module modem_result_code_classifier_top #(
  parameter int MAX_LINE = mrcc_pkg::MAX_LINE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [mrcc_pkg::CHAR_W-1:0]    s_tdata,   // [7:0] rx_char
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mrcc_pkg::OUT_W-1:0]     m_tdata    // [3:0] result_code, [11:4] line_length
);
  import mrcc_pkg::*;

  localparam int CNT_W = $clog2(MAX_LINE);

  logic                  inside_line;
  logic [CNT_W-1:0]      chars_in_line;
  logic [CNT_W+LEN_W-1:0] cnt_ext;
  logic                  accept;
  logic                  is_break;
  logic                  full;
  logic                  start;
  logic                  take;
  logic                  res_valid;
  logic [NUM_KEYS-1:0]   seen;
  logic [OUT_W-1:0]      res_data;

  assign accept    = s_tvalid && s_tready;
  assign is_break  = (s_tdata == CHAR_CR) || (s_tdata == CHAR_LF);
  assign full      = chars_in_line == CNT_W'(MAX_LINE - 1);
  assign start     = accept && !inside_line && !is_break;
  assign take      = start || (accept && inside_line && !is_break && !full);
  assign res_valid = accept && inside_line && (is_break || full);
  assign cnt_ext   = {{LEN_W{1'b0}}, chars_in_line};
  assign res_data  = {{(OUT_W - LEN_W - CODE_W){1'b0}}, cnt_ext[LEN_W-1:0], first_code(seen)};

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_line   <= 1'b0;
      chars_in_line <= '0;
    end else if (start) begin
      inside_line   <= 1'b1;
      chars_in_line <= CNT_W'(1);
    end else if (take) begin
      chars_in_line <= chars_in_line + 1'b1;
    end else if (res_valid) begin
      inside_line   <= 1'b0;
      chars_in_line <= '0;
    end
  end

  mrcc_window u_window (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .start   (start),
    .char_in (s_tdata),
    .seen    (seen)
  );

  mrcc_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_data  (res_data),
    .in_ready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  `MRCC_ASSERT(a_open_has_count, clk, rst, inside_line |-> (chars_in_line != '0), "open line with zero count")
  `MRCC_ASSERT(a_break_closes, clk, rst, (accept && inside_line && is_break) |=> !inside_line, "line not closed")
  `MRCC_ASSERT_ALWAYS(a_code_range, clk, (!rst && m_tvalid) |-> (m_tdata[CODE_W-1:0] <= CODE_NONE), "bad result code")

endmodule

// ===== bench/modem_result_code_classifier_top_tb.sv =====
module modem_result_code_classifier_top_tb;

  localparam int LINE_MAX       = 256;
  localparam int WIN            = mrcc_pkg::WIN_DEPTH;
  localparam int NUM_KEYS       = mrcc_pkg::NUM_KEYS;
  localparam int STALL_LIMIT    = 5000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS    = 210;

  typedef enum logic [3:0] {
    RC_OK, RC_ERROR, RC_CONNECT, RC_NO_CARRIER, RC_NO_DIALTONE, RC_BUSY,
    RC_DELAYED, RC_VOICE, RC_FAX, RC_NO_ANSWER, RC_NONE
  } result_code_t;

  typedef struct packed {
    result_code_t code;
    logic [7:0]   line_len;
  } line_result_t;

  string kw_text [NUM_KEYS] = '{
    "ok", "error", "connect", "no carrier", "no dialtone", "no dial tone",
    "busy", "delayed", "voice", "fclass", "fax", "no answer"
  };
  result_code_t kw_code [NUM_KEYS] = '{
    RC_OK, RC_ERROR, RC_CONNECT, RC_NO_CARRIER, RC_NO_DIALTONE, RC_NO_DIALTONE,
    RC_BUSY, RC_DELAYED, RC_VOICE, RC_FAX, RC_FAX, RC_NO_ANSWER
  };

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [mrcc_pkg::CHAR_W-1:0] s_tdata = '0;   // [7:0] rx_char
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [mrcc_pkg::OUT_W-1:0]  m_tdata;        // [3:0] result_code, [11:4] line_length

  // line classifier state
  logic [7:0]          line_win [WIN];
  logic [NUM_KEYS-1:0] kw_hits = '0;
  int                  kept_count = 0;
  bit                  line_open = 1'b0;

  line_result_t expected_lines [$];
  int           useful_items = 0;
  int           mismatch_count = 0;
  int           send_idle_pct = 0;
  int           rx_stall_pct = 0;
  bit           rx_hold_req = 1'b0;
  int           rx_hold_left = 0;
  int           quiet_cycles = 0;

  modem_result_code_classifier_top #(
    .MAX_LINE(LINE_MAX)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // fold, match keywords ending at this char, then shift it into the window
  task automatic shift_in(input logic [7:0] raw);
    logic [7:0] ch;
    logic [7:0] recent [WIN+1];
    bit         hit;
    int         len;
    ch = (raw >= 8'h41 && raw <= 8'h5A) ? raw + 8'h20 : raw;
    recent[0] = ch;
    for (int i = 0; i < WIN; i++) recent[i+1] = line_win[i];
    for (int k = 0; k < NUM_KEYS; k++) begin
      len = kw_text[k].len();
      hit = 1'b1;
      for (int j = 0; j < len; j++) begin
        if (recent[len-1-j] != 8'(kw_text[k][j])) hit = 1'b0;
      end
      if (hit) kw_hits[k] = 1'b1;
    end
    for (int i = WIN - 1; i > 0; i--) line_win[i] = line_win[i-1];
    line_win[0] = ch;
  endtask

  task automatic classify_char(input logic [7:0] raw);
    line_result_t res;
    bit           brk;
    brk = (raw == mrcc_pkg::CHAR_CR) || (raw == mrcc_pkg::CHAR_LF);
    if (!line_open) begin
      if (!brk) begin
        foreach (line_win[i]) line_win[i] = '0;
        kw_hits = '0;
        kept_count = 1;
        line_open = 1'b1;
        useful_items++;
        shift_in(raw);
      end
    end else if (brk || kept_count + 1 >= LINE_MAX) begin
      // the closing byte is not kept
      res.code = RC_NONE;
      for (int k = NUM_KEYS - 1; k >= 0; k--) begin
        if (kw_hits[k]) res.code = kw_code[k];
      end
      res.line_len = 8'(kept_count);
      expected_lines.push_back(res);
      line_open = 1'b0;
      useful_items++;
    end else begin
      shift_in(raw);
      kept_count++;
      useful_items++;
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'($urandom);
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    classify_char(c);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(8'(s[i]));
  endtask

  task automatic wait_lines_done();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_lines.size() != 0) @(negedge clk);
  endtask

  // only while the sender is parked
  task automatic set_idling(input int send_pct, input int rx_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    rx_stall_pct = rx_pct;
    @(negedge clk);
  endtask

  task automatic send_random_line();
    logic [7:0] text_q [$];
    logic [7:0] c;
    bit         long_line;
    int         n_pieces;
    int         k;
    int         cut;
    if ($urandom_range(9) == 0)
      text_q.push_back($urandom_range(1) ? mrcc_pkg::CHAR_CR : mrcc_pkg::CHAR_LF);
    long_line = ($urandom_range(79) == 0);
    n_pieces = long_line ? 70 : $urandom_range(0, 4);
    repeat (n_pieces) begin
      k = $urandom_range(NUM_KEYS - 1);
      case ($urandom_range(9))
        0, 1, 2, 3, 4: cut = kw_text[k].len();
        5, 6: cut = $urandom_range(1, kw_text[k].len() - 1);
        default: cut = 0;
      endcase
      for (int j = 0; j < cut; j++) begin
        c = 8'(kw_text[k][j]);
        if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1)) c = c - 8'h20;
        text_q.push_back(c);
      end
      if (cut == 0) begin
        if ($urandom_range(2) == 0) text_q.push_back(8'($urandom));
        else repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(8'h20, 8'h7A)));
      end
    end
    case ($urandom_range(7))
      0, 1, 2, 3: text_q.push_back(mrcc_pkg::CHAR_CR);
      4, 5: text_q.push_back(mrcc_pkg::CHAR_LF);
      6: begin
        text_q.push_back(mrcc_pkg::CHAR_CR);
        text_q.push_back(mrcc_pkg::CHAR_LF);
      end
      default: ;
    endcase
    foreach (text_q[i]) send_char(text_q[i]);
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send_text("\015\n\nOk\015");
    send_char(8'h00);
    send_char(8'hFF);
    send_text("@[\140{ZA\n");
    send_text("busy ok\015");
    wait_lines_done();
  endtask

  task automatic test_full_line();
    set_idling(0, 0);
    // dropped byte would have completed a keyword
    repeat (253) send_char(8'h7A);
    send_text("faX");
    send_text("Ok\015");
    repeat (240) send_char(8'h78);
    send_text("NO ANSWERxxxxxx");
    send_text("Q\n");
    repeat (254) send_char(8'h79);
    send_char(mrcc_pkg::CHAR_LF);
    wait_lines_done();
  endtask

  task automatic test_rx_hold_off();
    set_idling(0, 0);
    @(posedge clk);
    rx_hold_req = 1'b1;
    @(negedge clk);
    repeat (8) send_text("OK\015");
    wait_lines_done();
  endtask

  task automatic test_random_phases();
    int start;
    int send_pct [4] = '{0, 70, 0, 29};
    int rx_pct   [4] = '{0, 0, 70, 29};
    for (int p = 0; p < 4; p++) begin
      set_idling(send_pct[p], rx_pct[p]);
      start = useful_items;
      while (useful_items - start < PHASE_ITEMS) send_random_line();
      wait_lines_done();
    end
  endtask

  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = RX_HOLD_CYCLES;
      rx_hold_req = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    line_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_lines.size() == 0) begin
        report_mismatch($sformatf("result with none expected, tdata %h", m_tdata));
      end else begin
        want = expected_lines.pop_front();
        if (m_tdata[3:0] != want.code)
          report_mismatch($sformatf("result_code %0d, want %0d", m_tdata[3:0], want.code));
        if (m_tdata[11:4] != want.line_len)
          report_mismatch($sformatf("line_length %0d, want %0d", m_tdata[11:4], want.line_len));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TIMEOUT: no item moved for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_full_line();
    test_rx_hold_off();
    test_random_phases();
    wait_lines_done();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
